// File: hw/rtl/limit_order_matching_engine_unit_assert.svh
// Assertion macros shared by the order book RTL.
`ifndef LIMIT_ORDER_MATCHING_ENGINE_UNIT_ASSERT_SVH
`define LIMIT_ORDER_MATCHING_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and masked while arst_n is low.
`define LOME_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and masked while arst_n is low.
`define LOME_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lome_pkg.sv
// Shared types, codes and constants of the limit order matching engine.
package lome_pkg;

	localparam int ORDER_DEPTH_DEF = 32;
	localparam int LEVEL_DEPTH_DEF = 32;

	localparam int TYPE_W  = 2;
	localparam int ID_W    = 32;
	localparam int PRICE_W = 24;
	localparam int QTY_W   = 20;
	localparam int STAT_W  = 3;

	// Request kinds.
	localparam logic [TYPE_W-1:0] REQ_NEW    = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_CANCEL = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY  = 2'd2;

	// Status codes of the final item of a request.
	localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
	localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STAT_W-1:0] ST_CANCEL  = 3'd3;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;
	localparam logic [STAT_W-1:0] ST_FILL    = 3'd5;
	localparam logic [STAT_W-1:0] ST_NOFILL  = 3'd6;

	typedef enum logic [4:0] {
		S_IDLE,
		S_M_CHK, S_M_LV, S_M_EN, S_M_FILL, S_M_NXT, S_M_LVEND,
		S_R_WALK, S_R_CMP, S_R_DEC, S_R_PRV, S_R_APP, S_R_TAIL, S_R_LVW,
		S_C_SCAN, S_C_WALK, S_C_CMP, S_C_UP, S_C_UPW, S_C_UN, S_C_UNW, S_C_LV, S_C_DRP,
		S_Q_WALK, S_Q_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               is_trade;
		logic [ID_W-1:0]    buyer_id;
		logic [ID_W-1:0]    seller_id;
		logic [PRICE_W-1:0] fill_price;
		logic [QTY_W-1:0]   fill_qty;
		logic [STAT_W-1:0]  status;
		logic               last;
	} res_t;

endpackage

// File: hw/rtl/lome_ffree.sv
// Lowest-numbered free slot finder over a vector of in-use flags.
module lome_ffree #(
	parameter int DEPTH = lome_pkg::ORDER_DEPTH_DEF,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic [DEPTH-1:0] used,
	output logic             found,
	output logic [IW-1:0]    idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!used[i]) begin
				found = 1'b1;
				idx   = IW'(i);
			end
		end
	end

endmodule

// File: hw/rtl/limit_order_matching_engine_unit.sv
// A new order sweeps the opposite side level by level, with a fill item for each resting order it
// trades with; any remainder then walks its own side to find or insert its level and rests, status item last.
// A cancel scans the order table one entry per cycle until a hit or the end of the table, then
// walks its side level by level and unlinks the order; a query walks the opposite side level by level.
// Throughput: one request at a time, s_tready only in idle; a held output register stalls each item.
// Reset (arst_n low, asynchronous) empties the book and returns to idle, where a request is taken.
`include "limit_order_matching_engine_unit_assert.svh"

module limit_order_matching_engine_unit #(
	parameter int ORDER_DEPTH = lome_pkg::ORDER_DEPTH_DEF,
	parameter int LEVEL_DEPTH = lome_pkg::LEVEL_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, low bit up: order_id[31:0], is_buy[32], limit_price[56:33],
	// order_qty[76:57], zero fill[79:77]
	input  logic [79:0]  s_tdata,
	// s_tuser: req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, low bit up: buyer_id[31:0], seller_id[63:32], fill_price[87:64],
	// fill_qty[107:88], status[110:108], zero fill[111]
	output logic [111:0] m_tdata,
	// m_tuser: is_trade[0]
	output logic [0:0]   m_tuser,
	output logic         m_tlast
);

	localparam int EIW = $clog2(ORDER_DEPTH);
	localparam int LIW = $clog2(LEVEL_DEPTH);
	// A level total never exceeds ORDER_DEPTH full-size orders.
	localparam int TW  = lome_pkg::QTY_W + EIW;

	// A link holds an index, or "none" when the flag is set.
	typedef struct packed {
		logic           none;
		logic [EIW-1:0] idx;
	} elink_t;

	typedef struct packed {
		logic           none;
		logic [LIW-1:0] idx;
	} llink_t;

	typedef struct packed {
		logic [lome_pkg::ID_W-1:0]    id;
		logic                         buy;
		logic [lome_pkg::PRICE_W-1:0] price;
		logic [lome_pkg::QTY_W-1:0]   qty;
		elink_t                       prev;
		elink_t                       next;
	} entry_t;

	typedef struct packed {
		logic [lome_pkg::PRICE_W-1:0] price;
		logic [TW-1:0]                total;
		elink_t                       head;
		elink_t                       tail;
		llink_t                       next;
	} level_t;

	localparam elink_t ENONE = '{none: 1'b1, idx: '0};
	localparam llink_t LNONE = '{none: 1'b1, idx: '0};

	// ------------------------------------------------------------------
	// Table memories: resting orders and price levels. Each has one write
	// port and one read port whose data is registered, so a read issued in
	// one state is consumed in the state that follows it.
	// ------------------------------------------------------------------
	entry_t emem [ORDER_DEPTH];
	level_t lmem [LEVEL_DEPTH];
	entry_t erd_q;
	level_t lrd_q;

	logic           e_we;
	logic [EIW-1:0] e_wa;
	entry_t         e_wd;
	logic [EIW-1:0] e_ra;
	logic           l_we;
	logic [LIW-1:0] l_wa;
	level_t         l_wd;
	logic [LIW-1:0] l_ra;

	always_ff @(posedge clk) begin
		if (e_we) begin
			emem[e_wa] <= e_wd;
		end
		erd_q <= emem[e_ra];
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			lmem[l_wa] <= l_wd;
		end
		lrd_q <= lmem[l_ra];
	end

	// ------------------------------------------------------------------
	// Control state. best_q[0] heads the ask list (lowest first) and
	// best_q[1] the bid list (highest first).
	// ------------------------------------------------------------------
	lome_pkg::state_t state_q, state_d;
	llink_t best_q [2];
	llink_t best_d [2];
	logic [ORDER_DEPTH-1:0] eused_q, eused_d;
	logic [LEVEL_DEPTH-1:0] lused_q, lused_d;
	logic chk_vld_s1, chk_vld_d;

	// Request and working registers.
	logic [lome_pkg::ID_W-1:0]    id_q, id_d;
	logic                         buy_q, buy_d;
	logic [lome_pkg::PRICE_W-1:0] lim_q, lim_d;
	logic [lome_pkg::QTY_W-1:0]   rem_q, rem_d;
	entry_t                       en_q, en_d;
	logic [EIW-1:0]               ei_q, ei_d;
	level_t                       lv_q, lv_d;
	logic [LIW-1:0]               li_q, li_d;
	llink_t                       cur_q, cur_d;
	llink_t                       prv_q, prv_d;
	logic                         lvf_q, lvf_d;
	logic [EIW:0]                 cnt_q, cnt_d;
	logic [EIW-1:0]               chk_idx_s1, chk_idx_d;
	logic [TW:0]                  acc_q, acc_d;
	logic [lome_pkg::STAT_W-1:0]  stat_q, stat_d;
	logic [lome_pkg::QTY_W-1:0]   sqty_q, sqty_d;

	// Output register.
	lome_pkg::res_t o_q;
	logic           o_vld_q;
	logic           emit;
	lome_pkg::res_t emit_res;
	logic           room;

	// Free slot finders.
	logic           efree_found;
	logic [EIW-1:0] efree_idx;
	logic           lfree_found;
	logic [LIW-1:0] lfree_idx;

	lome_ffree #(.DEPTH(ORDER_DEPTH)) u_efree (
		.used  (eused_q),
		.found (efree_found),
		.idx   (efree_idx)
	);

	lome_ffree #(.DEPTH(LEVEL_DEPTH)) u_lfree (
		.used  (lused_q),
		.found (lfree_found),
		.idx   (lfree_idx)
	);

	// Input field views.
	logic [lome_pkg::ID_W-1:0]    in_id;
	logic                         in_buy;
	logic [lome_pkg::PRICE_W-1:0] in_price;
	logic [lome_pkg::QTY_W-1:0]   in_qty;
	logic [lome_pkg::TYPE_W-1:0]  in_type;

	assign in_id    = s_tdata[31:0];
	assign in_buy   = s_tdata[32];
	assign in_price = s_tdata[56:33];
	assign in_qty   = s_tdata[76:57];
	assign in_type  = s_tuser;

	assign s_tready = (state_q == lome_pkg::S_IDLE);
	assign room     = !o_vld_q || m_tready;

	// Helpers for the matching and query walks: the opposite side, whether
	// a level price crosses the limit, and the size of the next fill.
	logic                       opp;
	logic                       lrd_cross;
	logic                       lrd_better;
	logic [lome_pkg::QTY_W-1:0] tq;
	logic [TW:0]                qsum;

	assign opp        = !buy_q;
	assign lrd_cross  = buy_q ? (lrd_q.price <= lim_q) : (lrd_q.price >= lim_q);
	assign lrd_better = buy_q ? (lrd_q.price > lim_q) : (lrd_q.price < lim_q);
	assign tq         = (rem_q < en_q.qty) ? rem_q : en_q.qty;
	assign qsum       = acc_q + (TW + 1)'(lrd_q.total);

	always_comb begin
		state_d   = state_q;
		best_d[0] = best_q[0];
		best_d[1] = best_q[1];
		eused_d   = eused_q;
		lused_d   = lused_q;
		chk_vld_d = 1'b0;
		id_d      = id_q;
		buy_d     = buy_q;
		lim_d     = lim_q;
		rem_d     = rem_q;
		en_d      = en_q;
		ei_d      = ei_q;
		lv_d      = lv_q;
		li_d      = li_q;
		cur_d     = cur_q;
		prv_d     = prv_q;
		lvf_d     = lvf_q;
		cnt_d     = cnt_q;
		chk_idx_d = chk_idx_s1;
		acc_d     = acc_q;
		stat_d    = stat_q;
		sqty_d    = sqty_q;
		emit      = 1'b0;
		emit_res  = '0;
		e_we      = 1'b0;
		e_wa      = ei_q;
		e_wd      = en_q;
		e_ra      = ei_q;
		l_we      = 1'b0;
		l_wa      = li_q;
		l_wd      = lv_q;
		l_ra      = li_q;

		unique case (state_q)
			lome_pkg::S_IDLE: begin
				if (s_tvalid) begin
					id_d  = in_id;
					buy_d = in_buy;
					lim_d = in_price;
					rem_d = in_qty;
					acc_d = '0;
					cnt_d = '0;
					prv_d = LNONE;
					unique case (in_type)
						lome_pkg::REQ_NEW: begin
							if (in_qty == '0) begin
								stat_d  = lome_pkg::ST_ZERO;
								sqty_d  = '0;
								state_d = lome_pkg::S_DONE;
							end else begin
								state_d = lome_pkg::S_M_CHK;
							end
						end
						lome_pkg::REQ_CANCEL: begin
							state_d = lome_pkg::S_C_SCAN;
						end
						lome_pkg::REQ_QUERY: begin
							cur_d = best_q[!in_buy];
							if (in_qty == '0) begin
								stat_d  = lome_pkg::ST_NOFILL;
								sqty_d  = '0;
								state_d = lome_pkg::S_DONE;
							end else begin
								state_d = lome_pkg::S_Q_WALK;
							end
						end
						default: begin
							// Reserved request kind: plain done status.
							stat_d  = lome_pkg::ST_DONE;
							sqty_d  = '0;
							state_d = lome_pkg::S_DONE;
						end
					endcase
				end
			end

			// ---------------- matching sweep ----------------
			lome_pkg::S_M_CHK: begin
				if (rem_q == '0) begin
					stat_d  = lome_pkg::ST_DONE;
					sqty_d  = '0;
					state_d = lome_pkg::S_DONE;
				end else if (best_q[opp].none) begin
					cur_d   = best_q[buy_q];
					prv_d   = LNONE;
					state_d = lome_pkg::S_R_WALK;
				end else begin
					l_ra    = best_q[opp].idx;
					li_d    = best_q[opp].idx;
					state_d = lome_pkg::S_M_LV;
				end
			end

			lome_pkg::S_M_LV: begin
				if (!lrd_cross) begin
					cur_d   = best_q[buy_q];
					prv_d   = LNONE;
					state_d = lome_pkg::S_R_WALK;
				end else begin
					lv_d = lrd_q;
					if (lrd_q.head.none) begin
						state_d = lome_pkg::S_M_LVEND;
					end else begin
						e_ra    = lrd_q.head.idx;
						ei_d    = lrd_q.head.idx;
						state_d = lome_pkg::S_M_EN;
					end
				end
			end

			lome_pkg::S_M_EN: begin
				en_d    = erd_q;
				state_d = lome_pkg::S_M_FILL;
			end

			lome_pkg::S_M_FILL: begin
				if (room) begin
					emit                = 1'b1;
					emit_res.is_trade   = 1'b1;
					emit_res.buyer_id   = buy_q ? id_q : en_q.id;
					emit_res.seller_id  = buy_q ? en_q.id : id_q;
					emit_res.fill_price = lv_q.price;
					emit_res.fill_qty   = tq;
					emit_res.status     = lome_pkg::ST_DONE;
					rem_d               = rem_q - tq;
					lv_d.total          = lv_q.total - TW'(tq);
					if (en_q.qty == tq) begin
						// Head order used up: it leaves the front of the queue.
						eused_d[ei_q] = 1'b0;
						lv_d.head     = en_q.next;
						if (en_q.next.none) begin
							lv_d.tail = ENONE;
							state_d   = lome_pkg::S_M_LVEND;
						end else begin
							e_ra    = en_q.next.idx;
							ei_d    = en_q.next.idx;
							state_d = lome_pkg::S_M_NXT;
						end
					end else begin
						e_we       = 1'b1;
						e_wa       = ei_q;
						e_wd       = en_q;
						e_wd.qty   = en_q.qty - tq;
						state_d    = lome_pkg::S_M_LVEND;
					end
				end
			end

			lome_pkg::S_M_NXT: begin
				// The follower becomes the new head; clear its back link.
				en_d      = erd_q;
				en_d.prev = ENONE;
				e_we      = 1'b1;
				e_wa      = ei_q;
				e_wd      = erd_q;
				e_wd.prev = ENONE;
				state_d   = (rem_q != '0) ? lome_pkg::S_M_FILL : lome_pkg::S_M_LVEND;
			end

			lome_pkg::S_M_LVEND: begin
				if (!lv_q.head.none) begin
					l_we = 1'b1;
					l_wa = li_q;
					l_wd = lv_q;
				end else begin
					best_d[opp]   = lv_q.next;
					lused_d[li_q] = 1'b0;
				end
				state_d = lome_pkg::S_M_CHK;
			end

			// ---------------- resting the remainder ----------------
			lome_pkg::S_R_WALK: begin
				if (cur_q.none) begin
					lvf_d   = 1'b0;
					state_d = lome_pkg::S_R_DEC;
				end else begin
					l_ra    = cur_q.idx;
					state_d = lome_pkg::S_R_CMP;
				end
			end

			lome_pkg::S_R_CMP: begin
				if (lrd_q.price == lim_q) begin
					lvf_d   = 1'b1;
					lv_d    = lrd_q;
					li_d    = cur_q.idx;
					state_d = lome_pkg::S_R_DEC;
				end else if (lrd_better) begin
					prv_d   = cur_q;
					cur_d   = lrd_q.next;
					state_d = lome_pkg::S_R_WALK;
				end else begin
					// Levels are sorted, so the price is absent and cur_q
					// is where a new level would go.
					lvf_d   = 1'b0;
					state_d = lome_pkg::S_R_DEC;
				end
			end

			lome_pkg::S_R_DEC: begin
				if (!efree_found || (!lvf_q && !lfree_found)) begin
					stat_d  = lome_pkg::ST_FULL;
					sqty_d  = rem_q;
					state_d = lome_pkg::S_DONE;
				end else begin
					ei_d = efree_idx;
					if (!lvf_q) begin
						li_d               = lfree_idx;
						lused_d[lfree_idx] = 1'b1;
						lv_d.price         = lim_q;
						lv_d.total         = '0;
						lv_d.head          = ENONE;
						lv_d.tail          = ENONE;
						lv_d.next          = cur_q;
						if (prv_q.none) begin
							best_d[buy_q] = '{none: 1'b0, idx: lfree_idx};
							state_d       = lome_pkg::S_R_APP;
						end else begin
							l_ra    = prv_q.idx;
							state_d = lome_pkg::S_R_PRV;
						end
					end else begin
						state_d = lome_pkg::S_R_APP;
					end
				end
			end

			lome_pkg::S_R_PRV: begin
				l_we      = 1'b1;
				l_wa      = prv_q.idx;
				l_wd      = lrd_q;
				l_wd.next = '{none: 1'b0, idx: li_q};
				state_d   = lome_pkg::S_R_APP;
			end

			lome_pkg::S_R_APP: begin
				e_we          = 1'b1;
				e_wa          = ei_q;
				e_wd.id       = id_q;
				e_wd.buy      = buy_q;
				e_wd.price    = lim_q;
				e_wd.qty      = rem_q;
				e_wd.prev     = lv_q.tail;
				e_wd.next     = ENONE;
				eused_d[ei_q] = 1'b1;
				if (lv_q.tail.none) begin
					lv_d.head = '{none: 1'b0, idx: ei_q};
					state_d   = lome_pkg::S_R_LVW;
				end else begin
					e_ra    = lv_q.tail.idx;
					state_d = lome_pkg::S_R_TAIL;
				end
			end

			lome_pkg::S_R_TAIL: begin
				e_we      = 1'b1;
				e_wa      = lv_q.tail.idx;
				e_wd      = erd_q;
				e_wd.next = '{none: 1'b0, idx: ei_q};
				state_d   = lome_pkg::S_R_LVW;
			end

			lome_pkg::S_R_LVW: begin
				l_we       = 1'b1;
				l_wa       = li_q;
				l_wd       = lv_q;
				l_wd.tail  = '{none: 1'b0, idx: ei_q};
				l_wd.total = lv_q.total + TW'(rem_q);
				stat_d     = lome_pkg::ST_DONE;
				sqty_d     = rem_q;
				state_d    = lome_pkg::S_DONE;
			end

			// ---------------- cancel ----------------
			lome_pkg::S_C_SCAN: begin
				// Reads are issued one entry per cycle; the compare runs on
				// the entry read in the previous cycle.
				if (cnt_q < (EIW + 1)'(ORDER_DEPTH)) begin
					e_ra      = cnt_q[EIW-1:0];
					chk_vld_d = 1'b1;
					chk_idx_d = cnt_q[EIW-1:0];
					cnt_d     = cnt_q + 1'b1;
				end
				if (chk_vld_s1 && eused_q[chk_idx_s1] && (erd_q.id == id_q)) begin
					chk_vld_d = 1'b0;
					en_d      = erd_q;
					ei_d      = chk_idx_s1;
					cur_d     = best_q[erd_q.buy];
					prv_d     = LNONE;
					state_d   = lome_pkg::S_C_WALK;
				end else if (!chk_vld_s1 && (cnt_q == (EIW + 1)'(ORDER_DEPTH))) begin
					stat_d  = lome_pkg::ST_UNKNOWN;
					sqty_d  = '0;
					state_d = lome_pkg::S_DONE;
				end
			end

			lome_pkg::S_C_WALK: begin
				if (cur_q.none) begin
					eused_d[ei_q] = 1'b0;
					stat_d        = lome_pkg::ST_CANCEL;
					sqty_d        = en_q.qty;
					state_d       = lome_pkg::S_DONE;
				end else begin
					l_ra    = cur_q.idx;
					state_d = lome_pkg::S_C_CMP;
				end
			end

			lome_pkg::S_C_CMP: begin
				if (lrd_q.price == en_q.price) begin
					lv_d    = lrd_q;
					li_d    = cur_q.idx;
					state_d = lome_pkg::S_C_UP;
				end else begin
					prv_d   = cur_q;
					cur_d   = lrd_q.next;
					state_d = lome_pkg::S_C_WALK;
				end
			end

			lome_pkg::S_C_UP: begin
				lv_d.total = lv_q.total - TW'(en_q.qty);
				if (en_q.prev.none) begin
					lv_d.head = en_q.next;
					state_d   = lome_pkg::S_C_UN;
				end else begin
					e_ra    = en_q.prev.idx;
					state_d = lome_pkg::S_C_UPW;
				end
			end

			lome_pkg::S_C_UPW: begin
				e_we      = 1'b1;
				e_wa      = en_q.prev.idx;
				e_wd      = erd_q;
				e_wd.next = en_q.next;
				state_d   = lome_pkg::S_C_UN;
			end

			lome_pkg::S_C_UN: begin
				if (en_q.next.none) begin
					lv_d.tail = en_q.prev;
					state_d   = lome_pkg::S_C_LV;
				end else begin
					e_ra    = en_q.next.idx;
					state_d = lome_pkg::S_C_UNW;
				end
			end

			lome_pkg::S_C_UNW: begin
				e_we      = 1'b1;
				e_wa      = en_q.next.idx;
				e_wd      = erd_q;
				e_wd.prev = en_q.prev;
				state_d   = lome_pkg::S_C_LV;
			end

			lome_pkg::S_C_LV: begin
				eused_d[ei_q] = 1'b0;
				stat_d        = lome_pkg::ST_CANCEL;
				sqty_d        = en_q.qty;
				if (!lv_q.head.none) begin
					l_we    = 1'b1;
					l_wa    = li_q;
					l_wd    = lv_q;
					state_d = lome_pkg::S_DONE;
				end else begin
					lused_d[li_q] = 1'b0;
					if (prv_q.none) begin
						best_d[en_q.buy] = lv_q.next;
						state_d          = lome_pkg::S_DONE;
					end else begin
						l_ra    = prv_q.idx;
						state_d = lome_pkg::S_C_DRP;
					end
				end
			end

			lome_pkg::S_C_DRP: begin
				l_we      = 1'b1;
				l_wa      = prv_q.idx;
				l_wd      = lrd_q;
				l_wd.next = lv_q.next;
				state_d   = lome_pkg::S_DONE;
			end

			// ---------------- full-fill query ----------------
			lome_pkg::S_Q_WALK: begin
				if (cur_q.none) begin
					stat_d  = lome_pkg::ST_NOFILL;
					sqty_d  = '0;
					state_d = lome_pkg::S_DONE;
				end else begin
					l_ra    = cur_q.idx;
					state_d = lome_pkg::S_Q_CMP;
				end
			end

			lome_pkg::S_Q_CMP: begin
				sqty_d = '0;
				if (!lrd_cross) begin
					stat_d  = lome_pkg::ST_NOFILL;
					state_d = lome_pkg::S_DONE;
				end else if (qsum >= (TW + 1)'(rem_q)) begin
					stat_d  = lome_pkg::ST_FILL;
					state_d = lome_pkg::S_DONE;
				end else begin
					acc_d   = qsum;
					cur_d   = lrd_q.next;
					state_d = lome_pkg::S_Q_WALK;
				end
			end

			lome_pkg::S_DONE: begin
				if (room) begin
					emit              = 1'b1;
					emit_res.fill_qty = sqty_q;
					emit_res.status   = stat_q;
					emit_res.last     = 1'b1;
					state_d           = lome_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = lome_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lome_pkg::S_IDLE;
			best_q[0]  <= LNONE;
			best_q[1]  <= LNONE;
			eused_q    <= '0;
			lused_q    <= '0;
			chk_vld_s1 <= 1'b0;
			o_vld_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			best_q[0]  <= best_d[0];
			best_q[1]  <= best_d[1];
			eused_q    <= eused_d;
			lused_q    <= lused_d;
			chk_vld_s1 <= chk_vld_d;
			if (emit) begin
				o_vld_q <= 1'b1;
			end else if (m_tready) begin
				o_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		id_q       <= id_d;
		buy_q      <= buy_d;
		lim_q      <= lim_d;
		rem_q      <= rem_d;
		en_q       <= en_d;
		ei_q       <= ei_d;
		lv_q       <= lv_d;
		li_q       <= li_d;
		cur_q      <= cur_d;
		prv_q      <= prv_d;
		lvf_q      <= lvf_d;
		cnt_q      <= cnt_d;
		chk_idx_s1 <= chk_idx_d;
		acc_q      <= acc_d;
		stat_q     <= stat_d;
		sqty_q     <= sqty_d;
		if (emit) begin
			o_q <= emit_res;
		end
	end

	assign m_tvalid = o_vld_q;
	assign m_tdata  = {1'b0, o_q.status, o_q.fill_qty, o_q.fill_price, o_q.seller_id,
		o_q.buyer_id};
	assign m_tuser  = o_q.is_trade;
	assign m_tlast  = o_q.last;

	// A result is only pushed when the output register can take it.
	`LOME_ASSERT_IMP(a_emit_room, emit, room, "result pushed into an occupied output register")
	// The final item of a request always hands control back for the next request.
	`LOME_ASSERT_NXT(a_last_idle, emit && emit_res.last, state_q == lome_pkg::S_IDLE, "no idle")
	// The head of each side always names a level that is in use.
	`LOME_ASSERT_IMP(a_best_ask_used, !best_q[0].none, lused_q[best_q[0].idx], "best ask names a free level")
	`LOME_ASSERT_IMP(a_best_bid_used, !best_q[1].none, lused_q[best_q[1].idx], "best bid names a free level")

endmodule
